### rtl/dtti_pkg.sv
`default_nettype none
package dtti_pkg;

	// character codes
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// target width codes
	typedef enum logic [1:0] {
		TW_8  = 2'd0,
		TW_16 = 2'd1,
		TW_32 = 2'd2,
		TW_64 = 2'd3
	} twidth_t;

	// register indexes
	localparam logic REG_TARGET_WIDTH  = 1'b0;
	localparam logic REG_TARGET_SIGNED = 1'b1;

	// reset values of the registers
	localparam logic [1:0] TARGET_WIDTH_RST  = TW_32;
	localparam logic       TARGET_SIGNED_RST = 1'b1;

	// configuration seen by the converter
	typedef struct packed {
		logic [1:0] target_width;
		logic       target_signed;
	} cfg_t;

	// largest magnitude allowed for the target
	function automatic logic [63:0] limit_of(logic [1:0] w, logic sgn, logic neg);
		logic [63:0] umax;
		unique case (twidth_t'(w))
			TW_8:    umax = 64'h0000_0000_0000_00FF;
			TW_16:   umax = 64'h0000_0000_0000_FFFF;
			TW_32:   umax = 64'h0000_0000_FFFF_FFFF;
			TW_64:   umax = 64'hFFFF_FFFF_FFFF_FFFF;
			default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		if (sgn) begin
			limit_of = (umax >> 1) + {63'd0, neg};
		end else begin
			limit_of = umax;
		end
	endfunction

endpackage
`default_nettype wire

### rtl/dtti_char_if.sv
`default_nettype none
interface dtti_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface
`default_nettype wire

### rtl/dtti_res_if.sv
`default_nettype none
interface dtti_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

### rtl/dtti_cfg.sv
`default_nettype none
module dtti_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output dtti_pkg::cfg_t     cfg
);

	logic [1:0] target_width_q;
	logic       target_signed_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_width_q  <= dtti_pkg::TARGET_WIDTH_RST;
			target_signed_q <= dtti_pkg::TARGET_SIGNED_RST;
		end else if (wr_en) begin
			if (reg_sel == dtti_pkg::REG_TARGET_WIDTH) begin
				target_width_q <= pwdata[1:0];
			end else begin
				target_signed_q <= pwdata[0];
			end
		end
	end

	// read back
	always_comb begin
		if (reg_sel == dtti_pkg::REG_TARGET_WIDTH) begin
			prdata = {30'd0, target_width_q};
		end else begin
			prdata = {31'd0, target_signed_q};
		end
	end

	assign cfg.target_width  = target_width_q;
	assign cfg.target_signed = target_signed_q;

endmodule
`default_nettype wire

### rtl/dtti_core.sv
`default_nettype none
module dtti_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dtti_pkg::cfg_t cfg,
	dtti_char_if.sink           chars,
	dtti_res_if.source          results
);

	// input register
	logic       vld_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// per-string state
	logic [63:0]       mag_q;
	logic              neg_q;
	logic              at_start_q;
	dtti_pkg::status_t err_q;

	// result register
	logic              out_vld_q;
	logic [63:0]       out_value_q;
	dtti_pkg::status_t out_status_q;

	logic              out_free;
	logic              adv;
	logic              is_digit;
	logic [3:0]        digit;
	logic [63:0]       lim;
	logic [67:0]       prod;
	logic              fits;
	logic [63:0]       n_mag;
	logic              n_neg;
	logic              n_start;
	dtti_pkg::status_t n_err;
	dtti_pkg::status_t fin_st;
	logic [63:0]       fin_value;

	// handshake: non-final words never wait on the result side
	assign out_free    = !out_vld_q || results.ready;
	assign adv         = vld_s1 && (!last_s1 || out_free);
	assign chars.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	// digit step: magnitude * 10 + digit, checked exactly against the limit
	assign is_digit = (char_s1 >= dtti_pkg::CH_ZERO) && (char_s1 <= dtti_pkg::CH_NINE);
	assign digit    = 4'(char_s1 - dtti_pkg::CH_ZERO);
	assign lim      = dtti_pkg::limit_of(cfg.target_width, cfg.target_signed, neg_q);
	assign prod     = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {64'd0, digit};
	assign fits     = prod <= {4'd0, lim};

	always_comb begin
		n_mag   = mag_q;
		n_neg   = neg_q;
		n_start = at_start_q;
		n_err   = err_q;
		if (is_digit) begin
			n_start = 1'b0;
			if (err_q == dtti_pkg::ST_OK) begin
				if (fits) begin
					n_mag = prod[63:0];
				end else begin
					n_err = dtti_pkg::ST_RANGE;
				end
			end
		end else if (char_s1 == dtti_pkg::CH_MINUS && at_start_q && !neg_q
				&& cfg.target_signed) begin
			n_neg = 1'b1;
		end else begin
			n_err = dtti_pkg::ST_INVALID;
		end
	end

	// final status; a magnitude that is still ok was already checked on its last digit
	always_comb begin
		fin_st = n_err;
		if (fin_st != dtti_pkg::ST_INVALID && (n_start || (n_neg && !cfg.target_signed))) begin
			fin_st = dtti_pkg::ST_INVALID;
		end
		if (fin_st != dtti_pkg::ST_OK) begin
			fin_value = 64'd0;
		end else if (n_neg) begin
			fin_value = 64'd0 - n_mag;
		end else begin
			fin_value = n_mag;
		end
	end

	// state update, cleared after the final word of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q      <= 64'd0;
			neg_q      <= 1'b0;
			at_start_q <= 1'b1;
			err_q      <= dtti_pkg::ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				mag_q      <= 64'd0;
				neg_q      <= 1'b0;
				at_start_q <= 1'b1;
				err_q      <= dtti_pkg::ST_OK;
			end else begin
				mag_q      <= n_mag;
				neg_q      <= n_neg;
				at_start_q <= n_start;
				err_q      <= n_err;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_value_q  <= fin_value;
			out_status_q <= fin_st;
		end
	end

	assign results.valid  = out_vld_q;
	assign results.value  = out_value_q;
	assign results.status = out_status_q;

	// a string always starts over once its final word has gone through
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> at_start_q && !neg_q && mag_q == 64'd0
			&& err_q == dtti_pkg::ST_OK)
		else $error("string state not cleared after final word");

	// nothing accumulates before the first digit
	a_no_mag_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		at_start_q |-> mag_q == 64'd0)
		else $error("magnitude set before any digit");

	// a failed string carries a zero value
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_status_q != dtti_pkg::ST_OK |-> out_value_q == 64'd0)
		else $error("non-zero value with error status");

	// input is only held off by a waiting final word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> vld_s1 && last_s1 && out_vld_q && !results.ready)
		else $error("input stalled without cause");

endmodule
`default_nettype wire

### rtl/decimal_text_to_integer.sv
// A string's final character passes the input register, then loads the result register.
// Throughput: one character per cycle while the input is not held off; set by the magnitude
// update, a times-ten add and an exact compare against the target limit, all combinational.
// The input only waits while a result is held and the final character is queued behind it.
// Reset (arst_n low, asynchronous): target 32-bit signed, string state cleared, no result held.
`default_nettype none
module decimal_text_to_integer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	dtti_char_if.sink        chars,
	dtti_res_if.source       results
);

	dtti_pkg::cfg_t cfg;

	// configuration registers
	dtti_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// converter datapath
	dtti_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.chars   (chars),
		.results (results)
	);

endmodule
`default_nettype wire
